// ===== rtl/mmas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmas_pkg: shared types and codes of the matrix engine
// Request, result and datapath tag types, action, operation and register codes.
// ----------------------------------------------------------------------------
package mmas_pkg;

   localparam int DATA_W    = 32;
   localparam int POS_W     = 3;
   localparam int DIM_W     = 4;
   localparam int ACTION_W  = 2;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 4;

   // input actions
   localparam logic [ACTION_W-1:0] ACT_LOAD_A = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD_B = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_START  = 2'd2;

   // operation register codes
   localparam logic [OP_W-1:0] OP_MUL = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD = 2'd1;
   localparam logic [OP_W-1:0] OP_SUB = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COLS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_ROWS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COLS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OPERATION = 3'd4;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic [POS_W-1:0]         row_index;
      logic [POS_W-1:0]         col_index;
      logic signed [DATA_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]         result_row;
      logic [POS_W-1:0]         result_col;
      logic signed [DATA_W-1:0] result_value;
      logic                     last;
      logic                     dimension_error;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_MUL,
      KIND_ADD,
      KIND_SUB
   } kind_type;

   // control carried alongside each operand pair through the arithmetic unit
   typedef struct packed {
      kind_type         kind;
      logic             first;
      logic             last_k;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } tag_type;

endpackage

// ===== rtl/mmas_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmas_unit: shared multiply / add / accumulate unit
// Three stages: product or sum, scale and saturate, accumulate.
// ----------------------------------------------------------------------------
module mmas_unit #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  mmas_pkg::tag_type                 in_tag,
   input  logic signed [mmas_pkg::DATA_W-1:0] a_data,
   input  logic signed [mmas_pkg::DATA_W-1:0] b_data,
   output logic                              res_valid,
   output mmas_pkg::tag_type                 res_tag,
   output logic signed [mmas_pkg::DATA_W-1:0] res_value
);
   import mmas_pkg::*;

   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = DATA_W + $clog2(MAX_DIM) + 1;

   logic                     s2_valid_ff;
   tag_type                  s2_tag_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   logic                     s3_valid_ff;
   tag_type                  s3_tag_ff;
   logic signed [DATA_W-1:0] term_ff;
   logic signed [DATA_W-1:0] term_in;
   logic signed [PROD_W-1:0] scaled;

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  sum;

   // exact product, or sum / difference widened to the product width
   always_comb begin
      case (in_tag.kind)
         KIND_ADD: prod_in = PROD_W'(a_data) + PROD_W'(b_data);
         KIND_SUB: prod_in = PROD_W'(a_data) - PROD_W'(b_data);
         default:  prod_in = a_data * b_data;
      endcase
   end

   // drop fraction bits (floor) for products, then saturate
   always_comb begin
      if (s2_tag_ff.kind == KIND_MUL) begin
         scaled = prod_ff >>> FRAC_BITS;
      end else begin
         scaled = prod_ff;
      end
      if (scaled > PROD_W'(SAT_MAX)) begin
         term_in = SAT_MAX;
      end else if (scaled < PROD_W'(SAT_MIN)) begin
         term_in = SAT_MIN;
      end else begin
         term_in = DATA_W'(scaled);
      end
   end

   always_comb begin
      if (s3_tag_ff.first) begin
         sum = ACC_W'(term_ff);
      end else begin
         sum = acc_ff + ACC_W'(term_ff);
      end
      if (sum > ACC_W'(SAT_MAX)) begin
         res_value = SAT_MAX;
      end else if (sum < ACC_W'(SAT_MIN)) begin
         res_value = SAT_MIN;
      end else begin
         res_value = DATA_W'(sum);
      end
   end

   assign res_valid = s3_valid_ff && s3_tag_ff.last_k;
   assign res_tag   = s3_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_tag_ff <= in_tag;
      prod_ff   <= prod_in;
      s3_tag_ff <= s2_tag_ff;
      term_ff   <= term_in;
      if (s3_valid_ff) begin
         acc_ff <= sum;
      end
   end

endmodule

// ===== rtl/matrix_multiply_add_sub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_add_sub: matrix multiply / add / subtract engine
// Loads A and B elements by position and streams out the chosen operation.
// ----------------------------------------------------------------------------
// A transfer is taken at a clock edge with start high and busy low. Loads of
// A or B give no result; busy stays low. A start with legal dimensions raises
// busy and walks every output element in row-major order through one shared
// multiply / accumulate unit, one operand pair a cycle, rows*cols*K pairs in
// all, where K is a_cols for a matrix product and 1 for scaling, add and
// subtract. Each pair passes the store read port and the three unit stages
// before its result is registered at the output. Results appear at most one
// per cycle, each for exactly one cycle with rsp_valid high: the receiver has
// no way to stall them, so it must take every strobe. The final result of a
// run carries last, and busy is already low in that cycle. A start whose
// dimensions or operation do not fit returns a single error result in the
// following cycle without raising busy. Both stores read as zero after reset
// until an entry is written. Write the registers only while busy is low.
// ----------------------------------------------------------------------------
module matrix_multiply_add_sub #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mmas_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output mmas_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [mmas_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mmas_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import mmas_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_DIM);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      SEL_SCALE_A,
      SEL_SCALE_B,
      SEL_PRODUCT,
      SEL_ELEM
   } sel_type;

   // configuration registers
   logic [DIM_W-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic [OP_W-1:0]  operation_ff;

   // sequencer
   state_type        state_ff;
   sel_type          sel_ff;
   kind_type         kind_ff;
   logic [DIM_W-1:0] rows_m1_ff, cols_m1_ff, kn_m1_ff;
   logic [CW-1:0]    i_ff, j_ff, k_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   // decode of a start
   logic             start_ok;
   logic             reject;
   sel_type          start_sel;
   kind_type         start_kind;
   logic [DIM_W-1:0] start_rows, start_cols, start_kn;

   // stores
   logic [DATA_W-1:0] a_mem [DEPTH];
   logic [DATA_W-1:0] b_mem [DEPTH];
   logic [DEPTH-1:0]  a_vld_ff, b_vld_ff;
   logic [DATA_W-1:0] a_q_ff, b_q_ff;
   logic              a_hit_ff, b_hit_ff;
   logic [AW-1:0]     a_raddr, b_raddr, waddr;
   logic              load_ok, we_a, we_b, accept;

   // issue side
   logic             last_i, last_j, last_k;
   tag_type          issue_tag;
   logic             s1_valid_ff;
   tag_type          s1_tag_ff;
   logic signed [DATA_W-1:0] a_data, b_data;

   logic                     res_valid;
   tag_type                  res_tag;
   logic signed [DATA_W-1:0] res_value;

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
      return AW'(32'(r) * MAX_DIM + 32'(c));
   endfunction

   function automatic logic dim_ok(input logic [DIM_W-1:0] d);
      return (d != '0) && (32'(d) <= MAX_DIM);
   endfunction

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // ---- configuration writes -------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff    <= DIM_W'(1);
         a_cols_ff    <= DIM_W'(1);
         b_rows_ff    <= DIM_W'(1);
         b_cols_ff    <= DIM_W'(1);
         operation_ff <= OP_MUL;
      end else if (csr_we) begin
         case (csr_index)
            CSR_A_ROWS:    a_rows_ff    <= csr_wdata;
            CSR_A_COLS:    a_cols_ff    <= csr_wdata;
            CSR_B_ROWS:    b_rows_ff    <= csr_wdata;
            CSR_B_COLS:    b_cols_ff    <= csr_wdata;
            CSR_OPERATION: operation_ff <= csr_wdata[OP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- pick the run shape from the registers -----------------------------
   always_comb begin
      start_ok   = 1'b0;
      start_sel  = SEL_ELEM;
      start_kind = KIND_MUL;
      start_rows = a_rows_ff;
      start_cols = a_cols_ff;
      start_kn   = DIM_W'(1);
      if (dim_ok(a_rows_ff) && dim_ok(a_cols_ff) && dim_ok(b_rows_ff) && dim_ok(b_cols_ff)) begin
         case (operation_ff)
            OP_MUL: begin
               if (b_rows_ff == DIM_W'(1) && b_cols_ff == DIM_W'(1)) begin
                  start_ok  = 1'b1;
                  start_sel = SEL_SCALE_A;
               end else if (a_rows_ff == DIM_W'(1) && a_cols_ff == DIM_W'(1)) begin
                  start_ok   = 1'b1;
                  start_sel  = SEL_SCALE_B;
                  start_rows = b_rows_ff;
                  start_cols = b_cols_ff;
               end else if (a_cols_ff == b_rows_ff) begin
                  start_ok   = 1'b1;
                  start_sel  = SEL_PRODUCT;
                  start_cols = b_cols_ff;
                  start_kn   = a_cols_ff;
               end
            end
            OP_ADD, OP_SUB: begin
               if (a_rows_ff == b_rows_ff && a_cols_ff == b_cols_ff) begin
                  start_ok   = 1'b1;
                  start_sel  = SEL_ELEM;
                  start_kind = (operation_ff == OP_ADD) ? KIND_ADD : KIND_SUB;
               end
            end
            default: ;
         endcase
      end
   end

   // a start that does not fit: answer with the error transfer
   assign reject = accept && (req_data.action == ACT_START) && !start_ok;

   // ---- operand addresses and tag for the current step --------------------
   always_comb begin
      case (sel_ff)
         SEL_SCALE_A: begin
            a_raddr = addr_of(i_ff, j_ff);
            b_raddr = '0;
         end
         SEL_SCALE_B: begin
            a_raddr = '0;
            b_raddr = addr_of(i_ff, j_ff);
         end
         SEL_PRODUCT: begin
            a_raddr = addr_of(i_ff, k_ff);
            b_raddr = addr_of(k_ff, j_ff);
         end
         default: begin
            a_raddr = addr_of(i_ff, j_ff);
            b_raddr = addr_of(i_ff, j_ff);
         end
      endcase
   end

   assign last_i = (DIM_W'(i_ff) == rows_m1_ff);
   assign last_j = (DIM_W'(j_ff) == cols_m1_ff);
   assign last_k = (DIM_W'(k_ff) == kn_m1_ff);

   always_comb begin
      issue_tag.kind   = kind_ff;
      issue_tag.first  = (k_ff == '0);
      issue_tag.last_k = last_k;
      issue_tag.row    = POS_W'(i_ff);
      issue_tag.col    = POS_W'(j_ff);
      issue_tag.last   = last_i && last_j && last_k;
   end

   // ---- stores: one write port, one registered read port each -------------
   assign load_ok = (32'(req_data.row_index) < MAX_DIM) && (32'(req_data.col_index) < MAX_DIM);
   assign waddr   = AW'(32'(req_data.row_index) * MAX_DIM + 32'(req_data.col_index));
   assign we_a    = accept && load_ok && (req_data.action == ACT_LOAD_A);
   assign we_b    = accept && load_ok && (req_data.action == ACT_LOAD_B);

   always_ff @(posedge clock) begin
      if (we_a) begin
         a_mem[waddr] <= req_data.element_value;
      end
      if (we_b) begin
         b_mem[waddr] <= req_data.element_value;
      end
      a_q_ff <= a_mem[a_raddr];
      b_q_ff <= b_mem[b_raddr];
   end

   // written-entry flags: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
         b_vld_ff <= '0;
      end else begin
         if (we_a) begin
            a_vld_ff[waddr] <= 1'b1;
         end
         if (we_b) begin
            b_vld_ff[waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_hit_ff  <= a_vld_ff[a_raddr];
      b_hit_ff  <= b_vld_ff[b_raddr];
      s1_tag_ff <= issue_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= (state_ff == ST_RUN);
      end
   end

   assign a_data = a_hit_ff ? $signed(a_q_ff) : '0;
   assign b_data = b_hit_ff ? $signed(b_q_ff) : '0;

   mmas_unit #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_unit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_tag    (s1_tag_ff),
      .a_data    (a_data),
      .b_data    (b_data),
      .res_valid (res_valid),
      .res_tag   (res_tag),
      .res_value (res_value)
   );

   // ---- sequencer and result register -------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start && req_data.action == ACT_START) begin
                  if (start_ok) begin
                     sel_ff     <= start_sel;
                     kind_ff    <= start_kind;
                     rows_m1_ff <= start_rows - DIM_W'(1);
                     cols_m1_ff <= start_cols - DIM_W'(1);
                     kn_m1_ff   <= start_kn - DIM_W'(1);
                     i_ff       <= '0;
                     j_ff       <= '0;
                     k_ff       <= '0;
                     state_ff   <= ST_RUN;
                  end else begin
                     // bad shape: single error transfer
                     rsp_ff.result_row           <= '0;
                     rsp_ff.result_col           <= '0;
                     rsp_ff.result_value         <= '0;
                     rsp_ff.last                 <= 1'b1;
                     rsp_ff.dimension_error      <= 1'b1;
                  end
               end
            end
            ST_RUN: begin
               // advance k innermost, then column, then row
               if (!last_k) begin
                  k_ff <= k_ff + CW'(1);
               end else begin
                  k_ff <= '0;
                  if (!last_j) begin
                     j_ff <= j_ff + CW'(1);
                  end else begin
                     j_ff <= '0;
                     if (!last_i) begin
                        i_ff <= i_ff + CW'(1);
                     end else begin
                        state_ff <= ST_DRAIN;
                     end
                  end
               end
            end
            ST_DRAIN: ;
            default: state_ff <= ST_IDLE;
         endcase

         // strobe for one cycle on an error or a finished element
         rsp_valid_ff <= reject || res_valid;

         // hand each finished element to the output for one cycle
         if (res_valid) begin
            rsp_ff.result_row      <= res_tag.row;
            rsp_ff.result_col      <= res_tag.col;
            rsp_ff.result_value    <= res_value;
            rsp_ff.last            <= res_tag.last;
            rsp_ff.dimension_error <= 1'b0;
            if (res_tag.last) begin
               state_ff <= ST_IDLE;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/mmas_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmas_checker: port-level checks of the matrix engine
// Relates start transfers, busy and the result strobe over time.
// ----------------------------------------------------------------------------
module mmas_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input mmas_pkg::req_type req_data,
   input logic              rsp_valid,
   input mmas_pkg::rsp_type rsp_data
);
   import mmas_pkg::*;

   // a start either raises busy or answers with one error result
   a_start_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action == ACT_START |=>
         busy || (rsp_valid && rsp_data.dimension_error && rsp_data.last))
      else $error("start neither ran nor reported an error");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dimension_error |->
         rsp_data.last && rsp_data.result_value == '0)
      else $error("error result malformed");

   // the closing result is shown with busy already dropped
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("busy still high on final result");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("intermediate result outside a run");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action != ACT_START |=> !rsp_valid)
      else $error("result after a non-start transfer");

endmodule

bind matrix_multiply_add_sub mmas_checker u_mmas_checker (.*);
